/* hw/rtl/larb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// larb_pkg
// Shared types and constants for the light attenuation range bisection block:
// sequencer states, result codes, register indexes and the shared multiplier
// operand widths.
// ----------------------------------------------------------------------------
package larb_pkg;

   // Shared multiplier operand and product widths
   localparam int MUL_A_W = 25;
   localparam int MUL_B_W = 24;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   typedef logic [MUL_A_W-1:0] mul_a_type;
   typedef logic [MUL_B_W-1:0] mul_b_type;
   typedef logic [MUL_P_W-1:0] mul_p_type;

   // Denominator is Q33.16, saturated at 2^48
   localparam int DEN_W = 49;
   typedef logic [DEN_W-1:0] den_type;
   localparam den_type DEN_CAP = {1'b1, {(DEN_W-1){1'b0}}};

   // Coefficient fraction bits
   localparam int COEF_FRAC_BITS = 16;

   // floor(x / 10) for x below 2^18 as (x * DIV10_MULT) >> DIV10_SHIFT
   localparam int DIV10_MULT  = 209716;
   localparam int DIV10_SHIFT = 21;

   // Result codes
   localparam logic [1:0] OUTCOME_WITHIN  = 2'd0;
   localparam logic [1:0] OUTCOME_UNREACH = 2'd1;
   localparam logic [1:0] OUTCOME_EXHAUST = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_ACCURACY       = 2'd0;
   localparam logic [1:0] CSR_MAX_ITERATIONS = 2'd1;
   localparam logic [1:0] CSR_ZERO_THRESHOLD = 2'd2;
   localparam logic [1:0] CSR_SEARCH_LIMIT   = 2'd3;

   // Sequencer states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SETUP,
      ST_NEXT,
      ST_LIN,
      ST_QD,
      ST_TGET,
      ST_TLO,
      ST_THI,
      ST_TSUM,
      ST_QUAD,
      ST_DEN,
      ST_BLO,
      ST_BLH,
      ST_BHL,
      ST_BHH,
      ST_BHG,
      ST_DEC,
      ST_EXH,
      ST_FINISH
   } larb_state_type;

endpackage

/* hw/rtl/larb_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// larb_mul
// Shared unsigned multiplier with a registered product. Every product of the
// sequencer goes through this unit, one per cycle, ready in the next cycle.
// ----------------------------------------------------------------------------
module larb_mul (
   input  logic               clock,
   input  larb_pkg::mul_a_type op_a,
   input  larb_pkg::mul_b_type op_b,
   output larb_pkg::mul_p_type prod
);
   import larb_pkg::*;

   mul_p_type prod_ff;
   mul_p_type prod_in;

   // Form the full-width product
   assign prod_in = mul_p_type'(op_a) * mul_p_type'(op_b);

   // Register the product
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

/* hw/rtl/light_attenuation_range_bisection.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_attenuation_range_bisection
// For each request, finds the distance (Q14.DIST_FRAC_BITS) at which the
// brightness min(1, 1/(c + l*d + q*d*d)) falls within target +/- accuracy.
// It first tests the search limit; if the light is still too bright there it
// answers the limit with the unreachable code, otherwise it bisects [0, limit]
// for at most max_iterations steps. One request is worked at a time and
// req_ready is low until its result has been moved into the response
// register; a new request is taken while that response still waits. Every
// brightness probe runs on one shared 25x24 multiplier under the sequencer:
// a setup state ST_SETUP, then ST_LIN through ST_DEC for the limit probe and
// ST_NEXT, ST_LIN through ST_DEC for each bisection step, then ST_EXH when
// the step budget runs out, and ST_FINISH, which waits for the response
// register to be free and loads it. The block then returns to ST_IDLE before
// it can take the next request. The brightness test is done as a product
// compare against 2^(LEVEL_FRAC_BITS+16), so no divider is used.
// Configuration writes are taken only while no request is in work, and a
// waiting configuration write goes ahead of a waiting request.
// ----------------------------------------------------------------------------
module light_attenuation_range_bisection #(
   parameter int DIST_FRAC_BITS  = 10,
   parameter int LEVEL_FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [16:0] req_target_level,
   input  logic [23:0] req_coef_constant,
   input  logic [23:0] req_coef_linear,
   input  logic [23:0] req_coef_quadratic,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [23:0] rsp_distance,
   output logic [1:0]  rsp_outcome,
   // configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data
);
   import larb_pkg::*;

   // Widths that follow from the distance format
   localparam int TW    = 48 - DIST_FRAC_BITS;   // floor(x*d / 2^D) with 24-bit x
   localparam int CHUNK = MUL_B_W;               // split point for wide products
   localparam int ACCW  = 69;                    // t*d and band*den partial sums
   localparam int SUMW  = DEN_W + 1;
   localparam int CMPW  = (LEVEL_FRAC_BITS >= 18) ? LEVEL_FRAC_BITS + 1 : 19;
   localparam logic [ACCW-1:0] NUM = ACCW'(1) << (LEVEL_FRAC_BITS + COEF_FRAC_BITS);
   localparam logic [CMPW-1:0] FULL_LVL = CMPW'(1) << LEVEL_FRAC_BITS;
   localparam den_type UNITY_DEN = DEN_W'(1) << COEF_FRAC_BITS;

   // Control state
   larb_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           check_ff, check_in;
   logic [5:0]     iter_ff, iter_in;

   // Configuration registers
   logic [16:0] accuracy_ff, accuracy_in;
   logic [5:0]  max_iter_ff, max_iter_in;
   logic [16:0] zero_thr_ff, zero_thr_in;
   logic [23:0] limit_ff, limit_in;

   // Request payload
   logic [16:0] tgt_ff, tgt_in;
   logic [23:0] c_ff, c_in;
   logic [23:0] l_ff, l_in;
   logic [23:0] q_ff, q_in;

   // Search interval and probe
   logic [23:0] lo_ff, lo_in;
   logic [23:0] hi_ff, hi_in;
   logic [23:0] probe_ff, probe_in;

   // Brightness band
   logic        band_lo_pos_ff, band_lo_pos_in;
   logic [16:0] band_lo_ff, band_lo_in;
   logic [17:0] band_hi1_ff, band_hi1_in;

   // Denominator datapath
   logic [TW-1:0]   lin_ff, lin_in;
   logic [TW-1:0]   t_ff, t_in;
   logic [ACCW-1:0] acc_ff, acc_in;
   den_type         quad_ff, quad_in;
   den_type         den_ff, den_in;
   logic            lt_ff, lt_in;
   logic            gt_ff, gt_in;

   // Result staging and response register
   logic [23:0] res_dist_ff, res_dist_in;
   logic [1:0]  res_outcome_ff, res_outcome_in;
   logic [23:0] rsp_dist_ff, rsp_dist_in;
   logic [1:0]  rsp_outcome_ff, rsp_outcome_in;

   // Shared multiplier
   mul_a_type mul_a;
   mul_b_type mul_b;
   mul_p_type prod_ff;

   // Combinational helpers
   logic [16:0]     quot_w;
   logic [16:0]     acc_adj_w;
   logic [17:0]     lo_diff_w;
   logic [17:0]     hi_sum_w;
   logic [ACCW-1:0] psum_w;
   logic [ACCW-1:0] shift_w;
   den_type         quad_w;
   logic [SUMW-1:0] den_sum_w;
   logic            full_w;
   logic            lvl_lt_w;
   logic            lvl_gt_w;
   logic [23:0]     mid_w;

   larb_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod_ff)
   );

   // Adjust the accuracy and form the band from the divide-by-ten product
   assign quot_w    = prod_ff[DIV10_SHIFT+16:DIV10_SHIFT];
   assign acc_adj_w = ((tgt_ff != 17'd0) && (accuracy_ff >= tgt_ff)) ? quot_w : accuracy_ff;
   assign lo_diff_w = {1'b0, tgt_ff} - {1'b0, acc_adj_w};
   assign hi_sum_w  = 18'(tgt_ff) + 18'(acc_adj_w) + 18'd1;

   // Add the upper partial product onto the lower one
   assign psum_w = acc_ff + (ACCW'(prod_ff) << CHUNK);

   // Scale and saturate the quadratic term
   assign shift_w = acc_ff >> DIST_FRAC_BITS;
   always_comb begin
      if (|acc_ff[ACCW-1:63]) begin
         quad_w = DEN_CAP;
      end else if (shift_w > ACCW'(DEN_CAP)) begin
         quad_w = DEN_CAP;
      end else begin
         quad_w = shift_w[DEN_W-1:0];
      end
   end

   // Sum the three terms of the denominator
   assign den_sum_w = SUMW'(c_ff) + SUMW'(lin_ff) + SUMW'(quad_ff);

   // Resolve brightness against the band; small denominators give full scale
   assign full_w   = (den_ff <= DEN_W'(zero_thr_ff)) || (den_ff <= UNITY_DEN);
   assign lvl_lt_w = full_w ? (band_lo_pos_ff && (FULL_LVL < CMPW'(band_lo_ff))) : lt_ff;
   assign lvl_gt_w = full_w ? (FULL_LVL >= CMPW'(band_hi1_ff)) : gt_ff;

   // Midpoint of the current interval
   assign mid_w = lo_ff + ((hi_ff - lo_ff) >> 1);

   // Hold requests back while a configuration write waits
   assign req_ready    = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_dist_ff;
   assign rsp_outcome  = rsp_outcome_ff;

   // Sequencer: next state, datapath updates and multiplier operands
   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff;
      check_in       = check_ff;
      iter_in        = iter_ff;
      accuracy_in    = accuracy_ff;
      max_iter_in    = max_iter_ff;
      zero_thr_in    = zero_thr_ff;
      limit_in       = limit_ff;
      tgt_in         = tgt_ff;
      c_in           = c_ff;
      l_in           = l_ff;
      q_in           = q_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      probe_in       = probe_ff;
      band_lo_pos_in = band_lo_pos_ff;
      band_lo_in     = band_lo_ff;
      band_hi1_in    = band_hi1_ff;
      lin_in         = lin_ff;
      t_in           = t_ff;
      acc_in         = acc_ff;
      quad_in        = quad_ff;
      den_in         = den_ff;
      lt_in          = lt_ff;
      gt_in          = gt_ff;
      res_dist_in    = res_dist_ff;
      res_outcome_in = res_outcome_ff;
      rsp_dist_in    = rsp_dist_ff;
      rsp_outcome_in = rsp_outcome_ff;
      mul_a          = '0;
      mul_b          = '0;

      // Drop the response once it is transferred
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               tgt_in   = req_target_level;
               c_in     = req_coef_constant;
               l_in     = req_coef_linear;
               q_in     = req_coef_quadratic;
               lo_in    = 24'd0;
               hi_in    = limit_ff;
               probe_in = limit_ff;
               iter_in  = 6'd0;
               check_in = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            // target / 10 through the shared multiplier
            mul_a    = mul_a_type'(DIV10_MULT);
            mul_b    = mul_b_type'(tgt_ff);
            state_in = ST_LIN;
         end
         ST_NEXT: begin
            probe_in = mid_w;
            state_in = ST_LIN;
         end
         ST_LIN: begin
            if (check_ff) begin
               band_lo_pos_in = !lo_diff_w[17] && (lo_diff_w != 18'd0);
               band_lo_in     = lo_diff_w[16:0];
               band_hi1_in    = hi_sum_w;
            end
            mul_a    = {1'b0, l_ff};
            mul_b    = probe_ff;
            state_in = ST_QD;
         end
         ST_QD: begin
            lin_in   = prod_ff[47:DIST_FRAC_BITS];
            mul_a    = {1'b0, q_ff};
            mul_b    = probe_ff;
            state_in = ST_TGET;
         end
         ST_TGET: begin
            t_in     = prod_ff[47:DIST_FRAC_BITS];
            state_in = ST_TLO;
         end
         ST_TLO: begin
            mul_a    = mul_a_type'(t_ff[CHUNK-1:0]);
            mul_b    = probe_ff;
            state_in = ST_THI;
         end
         ST_THI: begin
            acc_in   = ACCW'(prod_ff);
            mul_a    = mul_a_type'(t_ff[TW-1:CHUNK]);
            mul_b    = probe_ff;
            state_in = ST_TSUM;
         end
         ST_TSUM: begin
            acc_in   = psum_w;
            state_in = ST_QUAD;
         end
         ST_QUAD: begin
            quad_in  = quad_w;
            state_in = ST_DEN;
         end
         ST_DEN: begin
            if (den_sum_w > SUMW'(DEN_CAP)) begin
               den_in = DEN_CAP;
            end else begin
               den_in = den_sum_w[DEN_W-1:0];
            end
            state_in = ST_BLO;
         end
         ST_BLO: begin
            mul_a    = mul_a_type'(den_ff[CHUNK-1:0]);
            mul_b    = mul_b_type'(band_lo_ff);
            state_in = ST_BLH;
         end
         ST_BLH: begin
            acc_in   = ACCW'(prod_ff);
            mul_a    = mul_a_type'(den_ff[DEN_W-1:CHUNK]);
            mul_b    = mul_b_type'(band_lo_ff);
            state_in = ST_BHL;
         end
         ST_BHL: begin
            // floor(N/den) < band_lo  <=>  N < band_lo * den
            lt_in    = band_lo_pos_ff && (NUM < psum_w);
            mul_a    = mul_a_type'(den_ff[CHUNK-1:0]);
            mul_b    = mul_b_type'(band_hi1_ff);
            state_in = ST_BHH;
         end
         ST_BHH: begin
            acc_in   = ACCW'(prod_ff);
            mul_a    = mul_a_type'(den_ff[DEN_W-1:CHUNK]);
            mul_b    = mul_b_type'(band_hi1_ff);
            state_in = ST_BHG;
         end
         ST_BHG: begin
            // floor(N/den) > band_hi  <=>  N >= (band_hi + 1) * den
            gt_in    = (NUM >= psum_w);
            state_in = ST_DEC;
         end
         ST_DEC: begin
            if (check_ff) begin
               check_in = 1'b0;
               if (lvl_gt_w) begin
                  res_dist_in    = probe_ff;
                  res_outcome_in = OUTCOME_UNREACH;
                  state_in       = ST_FINISH;
               end else if (max_iter_ff == 6'd0) begin
                  state_in = ST_EXH;
               end else begin
                  state_in = ST_NEXT;
               end
            end else if (!lvl_lt_w && !lvl_gt_w) begin
               res_dist_in    = probe_ff;
               res_outcome_in = OUTCOME_WITHIN;
               state_in       = ST_FINISH;
            end else begin
               if (lvl_lt_w) begin
                  hi_in = probe_ff;
               end else begin
                  lo_in = probe_ff;
               end
               iter_in = iter_ff + 6'd1;
               if ((iter_ff + 6'd1) == max_iter_ff) begin
                  state_in = ST_EXH;
               end else begin
                  state_in = ST_NEXT;
               end
            end
         end
         ST_EXH: begin
            res_dist_in    = mid_w;
            res_outcome_in = OUTCOME_EXHAUST;
            state_in       = ST_FINISH;
         end
         ST_FINISH: begin
            // Hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_dist_in    = res_dist_ff;
               rsp_outcome_in = res_outcome_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Apply a configuration transfer
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ACCURACY:       accuracy_in = csr_data[16:0];
            CSR_MAX_ITERATIONS: max_iter_in = csr_data[5:0];
            CSR_ZERO_THRESHOLD: zero_thr_in = csr_data[16:0];
            CSR_SEARCH_LIMIT:   limit_in    = csr_data;
            default: begin
            end
         endcase
      end
   end

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         accuracy_ff  <= 17'd66;
         max_iter_ff  <= 6'd50;
         zero_thr_ff  <= 17'd7;
         limit_ff     <= 24'd10240000;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         accuracy_ff  <= accuracy_in;
         max_iter_ff  <= max_iter_in;
         zero_thr_ff  <= zero_thr_in;
         limit_ff     <= limit_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      check_ff       <= check_in;
      iter_ff        <= iter_in;
      tgt_ff         <= tgt_in;
      c_ff           <= c_in;
      l_ff           <= l_in;
      q_ff           <= q_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      probe_ff       <= probe_in;
      band_lo_pos_ff <= band_lo_pos_in;
      band_lo_ff     <= band_lo_in;
      band_hi1_ff    <= band_hi1_in;
      lin_ff         <= lin_in;
      t_ff           <= t_in;
      acc_ff         <= acc_in;
      quad_ff        <= quad_in;
      den_ff         <= den_in;
      lt_ff          <= lt_in;
      gt_ff          <= gt_in;
      res_dist_ff    <= res_dist_in;
      res_outcome_ff <= res_outcome_in;
      rsp_dist_ff    <= rsp_dist_in;
      rsp_outcome_ff <= rsp_outcome_in;
   end

   // Interval never inverts while a request is in work
   a_interval_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (lo_ff <= hi_ff))
      else $error("search interval inverted");

   // A bisection decision happens only below the step budget
   a_step_budget: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DEC && !check_ff) |-> (iter_ff < max_iter_ff))
      else $error("bisection step beyond max_iterations");

   // Bisection probe lies inside the interval
   a_probe_inside: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DEC && !check_ff) |-> (probe_ff >= lo_ff && probe_ff <= hi_ff))
      else $error("probe outside search interval");

   // Unreachable answer carries the search limit
   a_unreach_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && res_outcome_ff == OUTCOME_UNREACH)
      |-> (res_dist_ff == limit_ff))
      else $error("unreachable result without search limit");

   // Response carries a defined result code
   a_outcome_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_outcome_ff == OUTCOME_WITHIN ||
                        rsp_outcome_ff == OUTCOME_UNREACH ||
                        rsp_outcome_ff == OUTCOME_EXHAUST))
      else $error("undefined result code");

endmodule

/* tb/tb_light_attenuation_range_bisection.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_light_attenuation_range_bisection
// Self-checking bench for the light range bisection block. A behavioral
// predictor of the brightness curve and the bisection search computes each
// expected distance and outcome when a request transfer happens. Responses are
// compared field by field against the oldest prediction. The run covers
// directed field and register extremes, then random phases of light requests
// with varied settings and sender idle / receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_light_attenuation_range_bisection;
   import larb_pkg::*;

   localparam int DIST_FRAC      = 10;
   localparam int LEVEL_FRAC     = 16;
   localparam int NUM_PHASES     = 22;
   localparam int PHASE_REQUESTS = 65;
   localparam int DRAIN_LIMIT    = 50000;
   localparam int SETTLE_CYCLES  = 1000;
   localparam int PRINT_LIMIT    = 50;

   typedef struct packed {
      logic [16:0] target_level;
      logic [23:0] coef_constant;
      logic [23:0] coef_linear;
      logic [23:0] coef_quadratic;
   } light_request_type;

   typedef struct packed {
      logic [23:0] distance;
      logic [1:0]  outcome;
   } range_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [16:0] req_target_level = '0;
   logic [23:0] req_coef_constant = '0;
   logic [23:0] req_coef_linear = '0;
   logic [23:0] req_coef_quadratic = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [23:0] rsp_distance;
   logic [1:0]  rsp_outcome;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [23:0] csr_data = '0;

   // Register copies used by the predictor
   logic [16:0] cfg_accuracy       = 17'd66;
   logic [5:0]  cfg_max_iterations = 6'd50;
   logic [16:0] cfg_zero_threshold = 17'd7;
   logic [23:0] cfg_search_limit   = 24'd10240000;

   range_result_type expected_ranges[$];

   int unsigned req_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned error_count = 0;
   int unsigned sent_count = 0;
   int unsigned settings_count = 0;
   int unsigned within_count = 0;
   int unsigned unreach_count = 0;
   int unsigned exhaust_count = 0;

   light_attenuation_range_bisection #(
      .DIST_FRAC_BITS (DIST_FRAC),
      .LEVEL_FRAC_BITS(LEVEL_FRAC)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_target_level  (req_target_level),
      .req_coef_constant (req_coef_constant),
      .req_coef_linear   (req_coef_linear),
      .req_coef_quadratic(req_coef_quadratic),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_distance      (rsp_distance),
      .rsp_outcome       (rsp_outcome),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // 100 MHz clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop if the run hangs
   initial begin
      #200_000_000;
      $display("tb: failure");
      $finish;
   end

   task automatic report_mismatch(input string what);
      if (error_count < PRINT_LIMIT)
         $display("[%0t] MISMATCH: %s", $realtime, what);
      error_count++;
   endtask

   // Append one prediction at the tail of the queue
   task automatic enqueue_expected(input range_result_type res);
      expected_ranges.insert(expected_ranges.size(), res);
   endtask

   // Attenuation denominator c + l*d + q*d*d in Q33.16, saturated
   function automatic longint unsigned attenuation_denominator(
      input longint unsigned span,
      input longint unsigned c,
      input longint unsigned l,
      input longint unsigned q
   );
      longint unsigned lin;
      longint unsigned partial;
      longint unsigned quad;
      longint unsigned sum;
      lin = (l * span) >> DIST_FRAC;
      partial = (q * span) >> DIST_FRAC;
      if (span != 0 && partial > (64'h7FFF_FFFF_FFFF_FFFF / span))
         quad = DEN_CAP;
      else
         quad = (partial * span) >> DIST_FRAC;
      if (quad > DEN_CAP)
         quad = DEN_CAP;
      sum = c + lin + quad;
      return (sum > DEN_CAP) ? DEN_CAP : sum;
   endfunction

   // Brightness at a distance in level format, capped at full scale
   function automatic longint brightness_at(input longint unsigned span,
                                            input light_request_type item);
      longint unsigned full;
      longint unsigned den;
      longint unsigned level;
      full = 64'd1 << LEVEL_FRAC;
      den = attenuation_denominator(span, item.coef_constant, item.coef_linear,
                                    item.coef_quadratic);
      if (den <= cfg_zero_threshold)
         return longint'(full);
      level = (64'd1 << (LEVEL_FRAC + COEF_FRAC_BITS)) / den;
      if (level > full)
         level = full;
      return longint'(level);
   endfunction

   // Search the distance where brightness falls inside the accepted band
   function automatic range_result_type predict_range(input light_request_type item);
      longint unsigned acc;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      longint          target;
      longint          band_lo;
      longint          band_hi;
      longint          level;
      range_result_type res;
      acc = cfg_accuracy;
      target = longint'({47'd0, item.target_level});
      if (item.target_level != 0 && acc >= item.target_level)
         acc = item.target_level / 10;
      band_lo = target - longint'(acc);
      band_hi = target + longint'(acc);

      // Still too bright at the far end: give up with the limit
      if (brightness_at(cfg_search_limit, item) > band_hi) begin
         res.distance = cfg_search_limit;
         res.outcome = OUTCOME_UNREACH;
         return res;
      end

      lo = 0;
      hi = cfg_search_limit;
      for (int i = 0; i < cfg_max_iterations; i++) begin
         mid = lo + (hi - lo) / 2;
         level = brightness_at(mid, item);
         if (level < band_lo) begin
            hi = mid;
         end else if (level > band_hi) begin
            lo = mid;
         end else begin
            res.distance = mid[23:0];
            res.outcome = OUTCOME_WITHIN;
            return res;
         end
      end
      mid = lo + (hi - lo) / 2;
      res.distance = mid[23:0];
      res.outcome = OUTCOME_EXHAUST;
      return res;
   endfunction

   function automatic light_request_type light(input logic [16:0] target,
                                               input logic [23:0] c,
                                               input logic [23:0] l,
                                               input logic [23:0] q);
      light_request_type item;
      item.target_level = target;
      item.coef_constant = c;
      item.coef_linear = l;
      item.coef_quadratic = q;
      return item;
   endfunction

   // Random value with a random number of low bits kept
   function automatic logic [23:0] log_scaled(input int unsigned top_bits);
      logic [31:0] mask;
      mask = (32'd1 << $urandom_range(0, top_bits)) - 1;
      return 24'($urandom & mask);
   endfunction

   // Mostly plausible light setups, some raw noise over the full fields
   function automatic light_request_type random_light();
      light_request_type item;
      if ($urandom_range(99) < 75) begin
         item.target_level = ($urandom_range(19) == 0) ? 17'd65536 : 17'(log_scaled(16));
         item.coef_constant = ($urandom_range(3) == 0) ? log_scaled(24)
                                                       : 24'($urandom_range(16384, 131072));
         item.coef_linear = log_scaled(20);
         item.coef_quadratic = log_scaled(18);
      end else begin
         item.target_level = 17'($urandom);
         item.coef_constant = 24'($urandom);
         item.coef_linear = 24'($urandom);
         item.coef_quadratic = 24'($urandom);
      end
      return item;
   endfunction

   // Select sender idle / receiver stall mix
   task automatic set_traffic_mix(input int mode);
      case (mode % 4)
         0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin req_idle_pct = 53; rsp_stall_pct = 0;  end
         2: begin req_idle_pct = 0;  rsp_stall_pct = 53; end
         default: begin req_idle_pct = 8; rsp_stall_pct = 8; end
      endcase
   endtask

   // Drive one request and hold it until the transfer
   task automatic send_request(input light_request_type item);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid <= 1'b1;
      req_target_level <= item.target_level;
      req_coef_constant <= item.coef_constant;
      req_coef_linear <= item.coef_linear;
      req_coef_quadratic <= item.coef_quadratic;
      do @(posedge clock); while (!req_ready);
      enqueue_expected(predict_range(item));
      sent_count++;
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ACCURACY:       cfg_accuracy = value[16:0];
         CSR_MAX_ITERATIONS: cfg_max_iterations = value[5:0];
         CSR_ZERO_THRESHOLD: cfg_zero_threshold = value[16:0];
         CSR_SEARCH_LIMIT:   cfg_search_limit = value;
         default: ;
      endcase
   endtask

   // Write all four registers, then release the channel
   task automatic load_settings(input logic [23:0] accuracy,
                                input logic [23:0] iterations,
                                input logic [23:0] threshold,
                                input logic [23:0] limit);
      write_register(CSR_ACCURACY, accuracy);
      write_register(CSR_MAX_ITERATIONS, iterations);
      write_register(CSR_ZERO_THRESHOLD, threshold);
      write_register(CSR_SEARCH_LIMIT, limit);
      csr_valid <= 1'b0;
      settings_count++;
   endtask

   // Wait for outstanding responses; flag any that never come
   task automatic wait_for_responses();
      int unsigned waited;
      waited = 0;
      while (expected_ranges.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      while (expected_ranges.size() != 0) begin
         void'(expected_ranges.pop_front());
         report_mismatch("expected response never arrived");
      end
   endtask

   // Field extremes and special cases at the reset settings
   task automatic test_reset_defaults();
      set_traffic_mix(0);
      settings_count++;
      send_request(light(17'd0, 24'd0, 24'd0, 24'd0));
      send_request(light(17'd65536, 24'd0, 24'd0, 24'd0));
      send_request(light(17'h1FFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
      send_request(light(17'd32768, 24'd65536, 24'd0, 24'd655));
      // accuracy shrinks to a tenth of a small target
      send_request(light(17'd10, 24'd65536, 24'd6554, 24'd66));
      send_request(light(17'd1, 24'd65536, 24'd0, 24'd1));
      send_request(light(17'd66, 24'd65536, 24'd655, 24'd655));
      send_request(light(17'd67, 24'd65536, 24'd655, 24'd655));
      // never bright enough: bisection runs out
      send_request(light(17'd65536, 24'hFFFFFF, 24'd0, 24'd0));
      // denominator under the zero threshold: everywhere, then only near distance zero
      send_request(light(17'd1000, 24'd3, 24'd0, 24'd0));
      send_request(light(17'd65536, 24'd7, 24'd1, 24'd0));
      send_request(light(17'h15555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA));
      send_request(light(17'h0AAAA, 24'h555555, 24'hAAAAAA, 24'h555555));
      req_valid <= 1'b0;
      wait_for_responses();
   endtask

   // Register extremes: zero limit, zero iterations, full and oversized values
   task automatic test_register_extremes();
      for (int s = 0; s < 4; s++) begin
         set_traffic_mix(s);
         case (s)
            0: load_settings(24'd0, 24'd0, 24'd0, 24'd0);
            1: load_settings(24'd65536, 24'd63, 24'd65536, 24'hFFFFFF);
            2: load_settings(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd1);
            default: load_settings(24'd0, 24'd63, 24'd7, 24'd10240000);
         endcase
         send_request(light(17'd32768, 24'd65536, 24'd0, 24'd655));
         send_request(light(17'd65536, 24'd0, 24'd0, 24'd0));
         send_request(light(17'd5000, 24'd131072, 24'd6554, 24'd7));
         req_valid <= 1'b0;
         wait_for_responses();
      end
   endtask

   // Random phases, each with fresh settings and a traffic mix
   task automatic test_random_traffic();
      logic [23:0] accuracy;
      logic [23:0] iterations;
      logic [23:0] threshold;
      logic [23:0] limit;
      for (int p = 0; p < NUM_PHASES; p++) begin
         case ($urandom_range(5))
            0: accuracy = 24'd0;
            1: accuracy = 24'd66;
            2: accuracy = 24'($urandom_range(1, 4000));
            3: accuracy = 24'($urandom_range(0, 65536));
            4: accuracy = 24'($urandom);
            default: accuracy = 24'($urandom_range(0, 600));
         endcase
         case ($urandom_range(9))
            0: iterations = 24'd63;
            1: iterations = 24'($urandom) & 24'hFFFFC0;
            default: iterations = 24'($urandom_range(1, 40));
         endcase
         if ($urandom_range(3) == 0)
            threshold = 24'($urandom);
         else
            threshold = 24'($urandom_range(0, 200));
         case ($urandom_range(4))
            0: limit = 24'd10240000;
            1: limit = 24'($urandom);
            2: limit = 24'($urandom_range(1, 20000));
            3: limit = 24'($urandom_range(0, 1 << 20));
            default: limit = 24'($urandom_range(1000000, 16777215));
         endcase
         set_traffic_mix(p);
         load_settings(accuracy, iterations, threshold, limit);
         for (int n = 0; n < PHASE_REQUESTS; n++)
            send_request(random_light());
         req_valid <= 1'b0;
         wait_for_responses();
      end
   endtask

   // Receiver: random stalls, compare each response with the oldest prediction
   always @(posedge clock) begin
      range_result_type want;
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_ranges.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = expected_ranges.pop_front();
            if (rsp_distance !== want.distance)
               report_mismatch($sformatf("distance %0d, expected %0d",
                                         rsp_distance, want.distance));
            if (rsp_outcome !== want.outcome)
               report_mismatch($sformatf("outcome %0d, expected %0d",
                                         rsp_outcome, want.outcome));
            case (want.outcome)
               OUTCOME_WITHIN:  within_count++;
               OUTCOME_UNREACH: unreach_count++;
               default:         exhaust_count++;
            endcase
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_register_extremes();
      test_random_traffic();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d requests over %0d register settings and four traffic mixes",
               sent_count, settings_count);
      $display("Checked outcomes: %0d within band, %0d unreachable, %0d exhausted",
               within_count, unreach_count, exhaust_count);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
